// ===== sv/ps2s2a_pkg.sv =====
package ps2s2a_pkg;

    localparam logic [7:0] CODE_BREAK  = 8'hF0;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;
    localparam logic [7:0] CODE_RSHIFT = 8'h59;

    localparam int CODE_W  = 8;
    localparam int ASCII_W = 7;

    typedef struct packed {
        logic shift_held;
        logic release_pending;
    } t_flags;

    typedef struct packed {
        logic               hit;
        logic [ASCII_W-1:0] plain;
        logic [ASCII_W-1:0] upper;
    } t_key;

    typedef struct packed {
        logic               emit;
        logic [ASCII_W-1:0] ascii_char;
    } t_result;

    function automatic t_key key_lookup(input logic [CODE_W-1:0] code);
        t_key k;
        k = '{1'b1, 7'h20, 7'h20};
        unique case (code)
            8'h0e: k = '{1'b1, 7'h7C, 7'h20};
            8'h15: k = '{1'b1, 7'h71, 7'h51};
            8'h16: k = '{1'b1, 7'h31, 7'h21};
            8'h1a: k = '{1'b1, 7'h7A, 7'h5A};
            8'h1b: k = '{1'b1, 7'h73, 7'h53};
            8'h1c: k = '{1'b1, 7'h61, 7'h41};
            8'h1d: k = '{1'b1, 7'h77, 7'h57};
            8'h1e: k = '{1'b1, 7'h32, 7'h22};
            8'h21: k = '{1'b1, 7'h63, 7'h43};
            8'h22: k = '{1'b1, 7'h78, 7'h58};
            8'h23: k = '{1'b1, 7'h64, 7'h44};
            8'h24: k = '{1'b1, 7'h65, 7'h45};
            8'h25: k = '{1'b1, 7'h34, 7'h24};
            8'h26: k = '{1'b1, 7'h33, 7'h20};
            8'h29: k = '{1'b1, 7'h20, 7'h20};
            8'h2a: k = '{1'b1, 7'h76, 7'h56};
            8'h2b: k = '{1'b1, 7'h66, 7'h46};
            8'h2c: k = '{1'b1, 7'h74, 7'h54};
            8'h2d: k = '{1'b1, 7'h72, 7'h52};
            8'h2e: k = '{1'b1, 7'h35, 7'h25};
            8'h31: k = '{1'b1, 7'h6E, 7'h4E};
            8'h32: k = '{1'b1, 7'h62, 7'h42};
            8'h33: k = '{1'b1, 7'h68, 7'h48};
            8'h34: k = '{1'b1, 7'h67, 7'h47};
            8'h35: k = '{1'b1, 7'h79, 7'h59};
            8'h36: k = '{1'b1, 7'h36, 7'h26};
            8'h39: k = '{1'b1, 7'h2C, 7'h3B};
            8'h3a: k = '{1'b1, 7'h6D, 7'h4D};
            8'h3b: k = '{1'b1, 7'h6A, 7'h4A};
            8'h3c: k = '{1'b1, 7'h75, 7'h55};
            8'h3d: k = '{1'b1, 7'h37, 7'h2F};
            8'h3e: k = '{1'b1, 7'h38, 7'h20};
            8'h41: k = '{1'b1, 7'h2C, 7'h3B};
            8'h42: k = '{1'b1, 7'h6B, 7'h4B};
            8'h43: k = '{1'b1, 7'h69, 7'h49};
            8'h44: k = '{1'b1, 7'h6F, 7'h4F};
            8'h45: k = '{1'b1, 7'h30, 7'h3D};
            8'h46: k = '{1'b1, 7'h39, 7'h20};
            8'h49: k = '{1'b1, 7'h2E, 7'h3A};
            8'h4a: k = '{1'b1, 7'h2D, 7'h5F};
            8'h4b: k = '{1'b1, 7'h6C, 7'h4C};
            8'h4c: k = '{1'b1, 7'h20, 7'h20};
            8'h4d: k = '{1'b1, 7'h70, 7'h50};
            8'h4e: k = '{1'b1, 7'h2B, 7'h2A};
            8'h52: k = '{1'b1, 7'h20, 7'h20};
            8'h54: k = '{1'b1, 7'h20, 7'h20};
            8'h55: k = '{1'b1, 7'h5C, 7'h20};
            8'h5a: k = '{1'b1, 7'h0D, 7'h0D};
            8'h5b: k = '{1'b1, 7'h20, 7'h20};
            8'h5d: k = '{1'b1, 7'h27, 7'h20};
            8'h61: k = '{1'b1, 7'h3C, 7'h3E};
            8'h66: k = '{1'b1, 7'h08, 7'h08};
            8'h69: k = '{1'b1, 7'h31, 7'h20};
            8'h6b: k = '{1'b1, 7'h34, 7'h20};
            8'h6c: k = '{1'b1, 7'h37, 7'h20};
            8'h70: k = '{1'b1, 7'h30, 7'h20};
            8'h71: k = '{1'b1, 7'h2C, 7'h20};
            8'h72: k = '{1'b1, 7'h32, 7'h20};
            8'h73: k = '{1'b1, 7'h35, 7'h20};
            8'h74: k = '{1'b1, 7'h36, 7'h20};
            8'h75: k = '{1'b1, 7'h38, 7'h20};
            8'h79: k = '{1'b1, 7'h2B, 7'h20};
            8'h7a: k = '{1'b1, 7'h33, 7'h20};
            8'h7b: k = '{1'b1, 7'h2D, 7'h20};
            8'h7c: k = '{1'b1, 7'h2A, 7'h20};
            8'h7d: k = '{1'b1, 7'h39, 7'h20};
            default: k = '{1'b0, 7'h00, 7'h00};
        endcase
        return k;
    endfunction

endpackage

// ===== sv/ps2_scancode_to_ascii.sv =====
// Channel   Dir  tdata bits (lowest up)        Handshake
// s_axis    in   [7:0] scan_code               tvalid/tready
// m_axis    out  [6:0] ascii_char, [7] zero    tvalid/tready
//
// One item per cycle sustained while m_axis_tready is high; a code passes the input register, then the result register.
// Input register feeds the table lookup and flag update; result register drives m_axis.
// Synchronous active-low reset clears both flags and both valid bits.
// A stalled result holds the input register; s_axis_tready stays high while the
// result register is empty or being taken.
module ps2_scancode_to_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [6:0] ascii_char, [7] zero
);

    logic                             r_in_valid;
    logic [ps2s2a_pkg::CODE_W-1:0]    r_code;
    ps2s2a_pkg::t_flags               r_flags;
    ps2s2a_pkg::t_flags               n_flags;
    ps2s2a_pkg::t_result              dec_result;
    logic                             r_out_valid;
    logic [ps2s2a_pkg::ASCII_W-1:0]   r_ascii;
    logic                             advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_ascii};

    ps2s2a_decode u_decode (
        .i_code   (r_code),
        .i_flags  (r_flags),
        .o_flags  (n_flags),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_flags     <= n_flags;
                r_out_valid <= dec_result.emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_code <= s_axis_tdata;
        end
        if (advance && dec_result.emit) begin
            r_ascii <= dec_result.ascii_char;
        end
    end

endmodule

// ===== sv/ps2s2a_decode.sv =====
module ps2s2a_decode (
    input  logic [ps2s2a_pkg::CODE_W-1:0] i_code,
    input  ps2s2a_pkg::t_flags            i_flags,
    output ps2s2a_pkg::t_flags            o_flags,
    output ps2s2a_pkg::t_result           o_result
);

    ps2s2a_pkg::t_key key;

    assign key = ps2s2a_pkg::key_lookup(i_code);

    always_comb begin
        o_flags             = i_flags;
        o_result.emit       = 1'b0;
        o_result.ascii_char = i_flags.shift_held ? key.upper : key.plain;
        priority if (i_flags.release_pending) begin
            o_flags.release_pending = 1'b0;
            if (i_code == ps2s2a_pkg::CODE_LSHIFT) begin
                o_flags.shift_held = 1'b0;
            end
        end else if (i_code == ps2s2a_pkg::CODE_BREAK) begin
            o_flags.release_pending = 1'b1;
        end else if (i_code == ps2s2a_pkg::CODE_LSHIFT) begin
            o_flags.shift_held = 1'b1;
        end else if (i_code == ps2s2a_pkg::CODE_RSHIFT) begin
            o_result.emit = 1'b0;
        end else begin
            o_result.emit = key.hit;
        end
    end

endmodule

// ===== sv/ps2s2a_checker.sv =====
module ps2s2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("result pad bit set");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_break_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata == ps2s2a_pkg::CODE_BREAK
        && m_axis_tready |=> ##1 !m_axis_tvalid || !$past(m_axis_tready))
        else $error("result after break prefix");

endmodule

bind ps2_scancode_to_ascii ps2s2a_checker u_ps2s2a_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    typedef enum logic [1:0] {BY_MODEL, NO_CHAR, TYPED_CHAR} t_row_kind;

    typedef struct packed {
        logic [ps2s2a_pkg::CODE_W-1:0]  code;
        t_row_kind                      kind;
        logic [ps2s2a_pkg::ASCII_W-1:0] ch;
    } t_row;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 650;
    localparam int HOLDOFF_LONG = 80;

    localparam t_row DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{8'h15,                   TYPED_CHAR, 7'h71},
        '{8'h00,                   NO_CHAR,    7'h00},
        '{8'hFF,                   NO_CHAR,    7'h00},
        '{8'h0e,                   TYPED_CHAR, 7'h7C},
        '{8'h7d,                   TYPED_CHAR, 7'h39},
        '{ps2s2a_pkg::CODE_LSHIFT, NO_CHAR,    7'h00},
        '{8'h15,                   TYPED_CHAR, 7'h51},
        '{8'h26,                   TYPED_CHAR, 7'h20},
        '{ps2s2a_pkg::CODE_RSHIFT, NO_CHAR,    7'h00},
        '{ps2s2a_pkg::CODE_BREAK,  NO_CHAR,    7'h00},
        '{ps2s2a_pkg::CODE_RSHIFT, NO_CHAR,    7'h00},
        '{8'h1c,                   TYPED_CHAR, 7'h41},
        '{ps2s2a_pkg::CODE_BREAK,  NO_CHAR,    7'h00},
        '{8'h1c,                   NO_CHAR,    7'h00},
        '{8'h5a,                   TYPED_CHAR, 7'h0D},
        '{ps2s2a_pkg::CODE_BREAK,  NO_CHAR,    7'h00},
        '{ps2s2a_pkg::CODE_BREAK,  NO_CHAR,    7'h00},
        '{8'h66,                   TYPED_CHAR, 7'h08},
        '{ps2s2a_pkg::CODE_BREAK,  NO_CHAR,    7'h00},
        '{ps2s2a_pkg::CODE_LSHIFT, NO_CHAR,    7'h00},
        '{8'h4a,                   TYPED_CHAR, 7'h2D},
        '{8'h80,                   NO_CHAR,    7'h00},
        '{8'h7f,                   NO_CHAR,    7'h00},
        '{8'h55,                   TYPED_CHAR, 7'h5C},
        '{8'h5d,                   BY_MODEL,   7'h00}
    };

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ps2s2a_pkg::CODE_W-1:0] s_axis_tdata  = '0;   // [7:0] scan_code
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;         // [6:0] ascii_char, [7] zero

    bit                             shift_down;
    bit                             break_armed;
    logic [ps2s2a_pkg::ASCII_W-1:0] chars_due [$];
    int                             errors;
    int                             send_calm;
    int                             take_calm;

    ps2_scancode_to_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // {plain, shifted} characters of a key, zero for a code outside the layout
    function automatic logic [15:0] key_pair(input logic [ps2s2a_pkg::CODE_W-1:0] code);
        case (code)
            8'h0e: return "| ";
            8'h15: return "qQ";
            8'h16: return "1!";
            8'h1a: return "zZ";
            8'h1b: return "sS";
            8'h1c: return "aA";
            8'h1d: return "wW";
            8'h1e: return "2\"";
            8'h21: return "cC";
            8'h22: return "xX";
            8'h23: return "dD";
            8'h24: return "eE";
            8'h25: return "4$";
            8'h26: return "3 ";
            8'h29: return "  ";
            8'h2a: return "vV";
            8'h2b: return "fF";
            8'h2c: return "tT";
            8'h2d: return "rR";
            8'h2e: return "5%";
            8'h31: return "nN";
            8'h32: return "bB";
            8'h33: return "hH";
            8'h34: return "gG";
            8'h35: return "yY";
            8'h36: return "6&";
            8'h39: return ",;";
            8'h3a: return "mM";
            8'h3b: return "jJ";
            8'h3c: return "uU";
            8'h3d: return "7/";
            8'h3e: return "8 ";
            8'h41: return ",;";
            8'h42: return "kK";
            8'h43: return "iI";
            8'h44: return "oO";
            8'h45: return "0=";
            8'h46: return "9 ";
            8'h49: return ".:";
            8'h4a: return "-_";
            8'h4b: return "lL";
            8'h4c: return "  ";
            8'h4d: return "pP";
            8'h4e: return "+*";
            8'h52: return "  ";
            8'h54: return "  ";
            8'h55: return "\\ ";
            8'h5a: return "\015\015";
            8'h5b: return "  ";
            8'h5d: return "' ";
            8'h61: return "<>";
            8'h66: return "\010\010";
            8'h69: return "1 ";
            8'h6b: return "4 ";
            8'h6c: return "7 ";
            8'h70: return "0 ";
            8'h71: return ", ";
            8'h72: return "2 ";
            8'h73: return "5 ";
            8'h74: return "6 ";
            8'h75: return "8 ";
            8'h79: return "+ ";
            8'h7a: return "3 ";
            8'h7b: return "- ";
            8'h7c: return "* ";
            8'h7d: return "9 ";
            default: return 16'h0000;
        endcase
    endfunction

    function automatic void decode_code(input logic [ps2s2a_pkg::CODE_W-1:0] code,
                                        output bit emits,
                                        output logic [ps2s2a_pkg::ASCII_W-1:0] ch);
        logic [15:0] pair;
        pair  = key_pair(code);
        emits = 1'b0;
        ch    = '0;
        if (break_armed) begin
            break_armed = 1'b0;
            if (code == ps2s2a_pkg::CODE_LSHIFT)
                shift_down = 1'b0;
        end else if (code == ps2s2a_pkg::CODE_BREAK) begin
            break_armed = 1'b1;
        end else if (code == ps2s2a_pkg::CODE_LSHIFT) begin
            shift_down = 1'b1;
        end else if (code != ps2s2a_pkg::CODE_RSHIFT && pair != 16'h0000) begin
            emits = 1'b1;
            ch    = shift_down ? pair[ps2s2a_pkg::ASCII_W-1:0]
                               : pair[8+ps2s2a_pkg::ASCII_W-1:8];
        end
    endfunction

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [ps2s2a_pkg::CODE_W-1:0] any_key();
        logic [ps2s2a_pkg::CODE_W-1:0] code;
        code = 8'($urandom_range(8'h0e, 8'h7d));
        while (key_pair(code) == 16'h0000)
            code = 8'($urandom_range(8'h0e, 8'h7d));
        return code;
    endfunction

    task automatic offer_code(input logic [ps2s2a_pkg::CODE_W-1:0] code);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_predicted(input logic [ps2s2a_pkg::CODE_W-1:0] code);
        bit                             emits;
        logic [ps2s2a_pkg::ASCII_W-1:0] ch;
        offer_code(code);
        decode_code(code, emits, ch);
        if (emits)
            chars_due.push_back(ch);
    endtask

    initial begin
        logic [ps2s2a_pkg::CODE_W-1:0]  strokes [$];
        logic [ps2s2a_pkg::CODE_W-1:0]  code;
        bit                             emits;
        logic [ps2s2a_pkg::ASCII_W-1:0] ch;
        int                             sent;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            offer_code(DIRECTED_ROWS[i].code);
            decode_code(DIRECTED_ROWS[i].code, emits, ch);
            case (DIRECTED_ROWS[i].kind)
                TYPED_CHAR: chars_due.push_back(DIRECTED_ROWS[i].ch);
                BY_MODEL:   if (emits) chars_due.push_back(ch);
                default:    ;
            endcase
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            if (strokes.size() == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        code = any_key();
                        strokes.push_back(code);
                        if ($urandom_range(0, 3) != 0) begin
                            strokes.push_back(ps2s2a_pkg::CODE_BREAK);
                            strokes.push_back(code);
                        end
                    end
                    6: strokes.push_back(ps2s2a_pkg::CODE_LSHIFT);
                    7: begin
                        strokes.push_back(ps2s2a_pkg::CODE_BREAK);
                        strokes.push_back(ps2s2a_pkg::CODE_LSHIFT);
                    end
                    8: begin
                        if ($urandom_range(0, 1))
                            strokes.push_back(ps2s2a_pkg::CODE_BREAK);
                        strokes.push_back(ps2s2a_pkg::CODE_RSHIFT);
                    end
                    default: strokes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_predicted(strokes.pop_front());
            sent++;
        end
        s_axis_tvalid <= 1'b0;

        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [ps2s2a_pkg::ASCII_W-1:0] want;
        int                             gap;
        int                             taken;

        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // hold off long enough for the block to back up into its input
            if (taken == 60 || taken == 200)
                gap = HOLDOFF_LONG;
            else
                gap = draw_gap(take_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected char, expected none, got %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = chars_due.pop_front();
                if (m_axis_tdata !== {1'b0, want}) begin
                    $display("%0t: char mismatch, expected %h, got %h",
                             $time, {1'b0, want}, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== ps2_scancode_to_ascii.f =====
sv/ps2s2a_pkg.sv
sv/ps2s2a_decode.sv
sv/ps2_scancode_to_ascii.sv
sv/ps2s2a_checker.sv
bench/tb_top.sv
